>>> rtl/assert_macros.svh
// assertion helpers, clocked on clk_i and held off while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define STM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define STM_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define STM_ASSERT(lbl, prop, msg)
`define STM_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

>>> rtl/stm_pkg.sv
package stm_pkg;

  localparam int SLOT_COUNT = 64;
  localparam int SLOT_AW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int IDX_W      = 6;
  localparam int TIME_W     = 64;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_STOP  = 2'd1,
    KIND_READ  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_UPD
  } state_e;

  // one slot row as stored in the slot ram, start stamp in the lowest bits
  typedef struct packed {
    logic [TIME_W-1:0] worst;
    logic [TIME_W-1:0] tally;
    logic [TIME_W-1:0] total;
    logic [TIME_W-1:0] start;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  typedef struct packed {
    logic load_in;    // capture the accepted beat, launch the row read
    logic clear_all;  // drop every slot back to zero
    logic latch_row;  // register the row and the span of a start or stop
    logic ram_we;     // write the updated row back
    logic load_out;   // load a read result into the output register
  } cmd_t;

  typedef struct packed {
    kind_e kind;      // kind of the item in flight
    logic  out_free;  // output register empty or emptied this cycle
  } sts_t;

endpackage

>>> rtl/stm_ram.sv
module stm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/stm_ctrl.sv
module stm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  stm_pkg::kind_e in_kind_i,
  output logic          in_ready_o,
  input  stm_pkg::sts_t sts_i,
  output stm_pkg::cmd_t cmd_o
);

  import stm_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_kind_i == KIND_CLEAR) begin
            cmd_o.clear_all = 1'b1;
          end else begin
            cmd_o.load_in = 1'b1;
            state_d       = ST_CALC;
          end
        end
      end
      ST_CALC: begin
        if (sts_i.kind == KIND_READ) begin
          // wait here while an earlier result is still unclaimed
          if (sts_i.out_free) begin
            cmd_o.load_out = 1'b1;
            state_d        = ST_IDLE;
          end
        end else begin
          cmd_o.latch_row = 1'b1;
          state_d         = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd_o.ram_we = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/stm_dp.sv
module stm_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  stm_pkg::cmd_t              cmd_i,
  output stm_pkg::sts_t              sts_o,
  input  stm_pkg::kind_e             in_kind_i,
  input  logic [stm_pkg::IDX_W-1:0]  in_idx_i,
  input  logic [stm_pkg::TIME_W-1:0] in_now_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [stm_pkg::TIME_W-1:0] out_total_o,
  output logic [stm_pkg::TIME_W-1:0] out_count_o,
  output logic [stm_pkg::TIME_W-1:0] out_worst_o,
  output logic                       ram_we_o
);

  import stm_pkg::*;

  kind_e               kind_q;
  logic [IDX_W-1:0]    idx_q;
  logic [TIME_W-1:0]   now_q;
  logic                in_range_q;
  logic [SLOT_AW-1:0]  addr_q;
  logic [SLOT_COUNT-1:0] valid_q;

  row_t                row_q;
  logic [TIME_W-1:0]   span_q;
  logic                later_q;

  logic                out_valid_q;
  logic [TIME_W-1:0]   out_total_q, out_count_q, out_worst_q;

  logic [ROW_W-1:0]    rdata;
  row_t                row_eff;
  row_t                row_new;
  logic                we;

  // slot ram, one row per slot
  stm_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SLOT_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (addr_q),
    .wdata_i (row_new),
    .re_i    (cmd_i.load_in),
    .raddr_i (SLOT_AW'(in_idx_i)),
    .rdata_o (rdata)
  );

  // item in flight
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      kind_q     <= in_kind_i;
      idx_q      <= in_idx_i;
      now_q      <= in_now_i;
      in_range_q <= (32'(in_idx_i) < SLOT_COUNT);
    end
  end

  assign addr_q = SLOT_AW'(idx_q);

  // a slot never written since reset or clear reads as zero
  assign row_eff = (in_range_q && valid_q[addr_q]) ? row_t'(rdata) : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_row) begin
      row_q   <= row_eff;
      later_q <= (row_eff.start < now_q);
      span_q  <= now_q - row_eff.start;
    end
  end

  always_comb begin
    row_new = row_q;
    if (kind_q == KIND_START) begin
      row_new.start = now_q;
    end else begin
      row_new.tally = row_q.tally + TIME_W'(1);
      if (later_q) begin
        row_new.total = row_q.total + span_q;
        if (span_q > row_q.worst) begin
          row_new.worst = span_q;
        end
      end
    end
  end

  assign we = cmd_i.ram_we && in_range_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.clear_all) begin
      valid_q <= '0;
    end else if (we) begin
      valid_q[addr_q] <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_total_q <= row_eff.total;
      out_count_q <= row_eff.tally;
      out_worst_q <= row_eff.worst;
    end
  end

  assign sts_o.kind     = kind_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_total_o = out_total_q;
  assign out_count_o = out_count_q;
  assign out_worst_o = out_worst_q;
  assign ram_we_o    = we;

endmodule

>>> rtl/section_timing_monitor.sv
// section timing monitor: a table of SLOT_COUNT timing slots (stm_pkg), each holding a start
// stamp, a running total, a stop count and a worst-case duration. tuser selects the kind of
// a beat: start records now in the slot; stop adds now minus the recorded start to the total
// and keeps it as worst case when the start is strictly below now, and counts the stop in
// every case; read returns one beat with total, count and worst case (all zero for a slot
// index beyond the table); clear zeroes every slot. only a read gives an output beat.
// totals and counts wrap at 2^64. steps: a clear is taken in the idle state; a read does
// accept and row read, then the output load, which waits while a result is unclaimed; a
// start or stop does accept and row read, compute, write back (registered read of the
// single slot ram, then read-modify-write of the row). a read result sits in an output
// register, so the next beat is taken while it waits; a second read waits for the first
// result to leave. reset and clear act at once via one valid bit per slot, no clearing pass.
`include "assert_macros.svh"

module section_timing_monitor (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,  // slot_index [5:0], now [69:6], zero [71:70]
  input  logic [1:0]  s_axis_tuser_i,  // kind [1:0]
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [191:0] m_axis_tdata_o  // total_time [63:0], stop_count [127:64],
                                       // worst_time [191:128]
);

  import stm_pkg::*;

  cmd_t  cmd;
  sts_t  sts;
  kind_e in_kind;
  logic  ram_we;
  logic  in_beat;
  logic  out_room;
  logic [TIME_W-1:0] total, count, worst;

  assign in_kind = kind_e'(s_axis_tuser_i);

  // handshakes seen at the ports
  assign in_beat  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_room = !m_axis_tvalid_o || m_axis_tready_i;

  // sequencer
  stm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_kind_i  (in_kind),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // slot storage, arithmetic and output register
  stm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_kind_i   (in_kind),
    .in_idx_i    (s_axis_tdata_i[IDX_W-1:0]),
    .in_now_i    (s_axis_tdata_i[IDX_W+TIME_W-1:IDX_W]),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_total_o (total),
    .out_count_o (count),
    .out_worst_o (worst),
    .ram_we_o    (ram_we)
  );

  assign m_axis_tdata_o = {worst, count, total};

  // a row write always follows the cycle that latched the row
  `STM_ASSERT(a_we_after_latch, ram_we |-> $past(cmd.latch_row), "row write without latch")
  // a result is never loaded over one that is still waiting
  `STM_ASSERT(a_no_overrun, cmd.load_out |-> out_room, "result overrun")
  // clear and capture act only on an accepted beat
  `STM_ASSERT(a_clear_on_beat, (cmd.clear_all || cmd.load_in) |-> in_beat, "command w/o beat")
  // no beat is taken while a row is being written back
  `STM_ASSERT_NEVER(a_no_accept_on_we, ram_we && s_axis_tready_o, "accept during write back")

endmodule
